FILE: src/cas_pkg.sv
package cas_pkg;

    localparam int CFG_W_W   = 6;
    localparam int CFG_H_W   = 11;
    localparam int THR_W     = 4;
    localparam int CNT_W     = 4;
    localparam int WIN_W     = 9;
    localparam int OUT_ROW_W = 10;
    localparam int OUT_COL_W = 5;
    localparam int APB_AW    = 4;
    localparam int APB_DW    = 32;

    localparam logic [CFG_W_W-1:0] RST_FRAME_WIDTH    = CFG_W_W'(32);
    localparam logic [CFG_H_W-1:0] RST_FRAME_HEIGHT   = CFG_H_W'(32);
    localparam logic [THR_W-1:0]   RST_LOW_THRESHOLD  = THR_W'(4);
    localparam logic [THR_W-1:0]   RST_HIGH_THRESHOLD = THR_W'(6);

    // window bit 3*r+k: r=0 top .. r=2 bottom; k=0 right, k=1 centre, k=2 left
    localparam logic [WIN_W-1:0] WIN_KEEP_MASK  = 9'h1B6;
    localparam logic [WIN_W-1:0] WIN_NEIGH_MASK = 9'h1EF;
    localparam int               WIN_CENTRE     = 4;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH    = 2'd0,
        REG_FRAME_HEIGHT   = 2'd1,
        REG_LOW_THRESHOLD  = 2'd2,
        REG_HIGH_THRESHOLD = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W_W-1:0] frame_width;
        logic [CFG_H_W-1:0] frame_height;
        logic [THR_W-1:0]   low_threshold;
        logic [THR_W-1:0]   high_threshold;
    } cfg_t;

    // one column shifted into the window, optionally producing a result
    typedef struct packed {
        logic                 clear;
        logic                 top;
        logic                 mid;
        logic                 bot;
        logic                 emit;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 frame_end;
    } ev_t;

endpackage

FILE: src/cas_regs.sv
module cas_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cas_pkg::APB_AW-1:0] paddr,
    input  logic [cas_pkg::APB_DW-1:0] pwdata,
    output logic [cas_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    output cas_pkg::cfg_t              cfg
);
    import cas_pkg::*;

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_idx;
    logic     wr_en;

    assign reg_idx = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_FRAME_WIDTH:    cfg_next.frame_width    = pwdata[CFG_W_W-1:0];
                REG_FRAME_HEIGHT:   cfg_next.frame_height   = pwdata[CFG_H_W-1:0];
                REG_LOW_THRESHOLD:  cfg_next.low_threshold  = pwdata[THR_W-1:0];
                REG_HIGH_THRESHOLD: cfg_next.high_threshold = pwdata[THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:    prdata = APB_DW'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT:   prdata = APB_DW'(cfg_reg.frame_height);
            REG_LOW_THRESHOLD:  prdata = APB_DW'(cfg_reg.low_threshold);
            REG_HIGH_THRESHOLD: prdata = APB_DW'(cfg_reg.high_threshold);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width    <= RST_FRAME_WIDTH;
            cfg_reg.frame_height   <= RST_FRAME_HEIGHT;
            cfg_reg.low_threshold  <= RST_LOW_THRESHOLD;
            cfg_reg.high_threshold <= RST_HIGH_THRESHOLD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: src/cas_line_store.sv
module cas_line_store #(
    parameter int LINE_MAX = 32
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [$clog2(LINE_MAX)-1:0] wr_addr,
    input  logic [1:0]                  wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(LINE_MAX)-1:0] rd_addr,
    output logic [1:0]                  rd_data
);
    // bit 0: row above, bit 1: row two above
    logic [1:0] line_mem [LINE_MAX];
    logic [1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= line_mem[rd_addr];
        end
    end

endmodule

FILE: src/cas_window.sv
module cas_window (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cas_pkg::cfg_t                 cfg,
    input  logic                          ev_valid,
    input  cas_pkg::ev_t                  ev,
    output logic                          ev_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_cell_out,
    output logic [cas_pkg::OUT_ROW_W-1:0] m_out_row,
    output logic [cas_pkg::OUT_COL_W-1:0] m_out_col,
    output logic                          m_frame_end
);
    import cas_pkg::*;

    logic [WIN_W-1:0]     window_reg, window_next, window_base;
    logic [CNT_W-1:0]     count;
    logic                 smooth_bit;
    logic                 go;
    logic                 m_valid_reg, m_valid_next;
    logic                 cell_out_reg;
    logic [OUT_ROW_W-1:0] out_row_reg;
    logic [OUT_COL_W-1:0] out_col_reg;
    logic                 frame_end_reg;

    assign ev_ready = !m_valid_reg || m_ready;
    assign go       = ev_valid && ev_ready;

    assign window_base = ev.clear ? '0 : window_reg;
    assign window_next = ((window_base << 1) & WIN_KEEP_MASK)
                       | {2'b00, ev.bot, 2'b00, ev.mid, 2'b00, ev.top};
    assign count       = CNT_W'($countones(window_next & WIN_NEIGH_MASK));

    always_comb begin
        if (count < cfg.low_threshold) begin
            smooth_bit = 1'b0;
        end else if (count >= cfg.high_threshold) begin
            smooth_bit = 1'b1;
        end else begin
            smooth_bit = window_next[WIN_CENTRE];
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (go && ev.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (go) begin
                window_reg <= window_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (go && ev.emit) begin
            cell_out_reg  <= smooth_bit;
            out_row_reg   <= ev.row;
            out_col_reg   <= ev.col;
            frame_end_reg <= ev.frame_end;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_cell_out  = cell_out_reg;
    assign m_out_row   = out_row_reg;
    assign m_out_col   = out_col_reg;
    assign m_frame_end = frame_end_reg;

endmodule

FILE: src/cellular_automaton_smoothing_top.sv
// channel  dir  handshake          payload
// s_       in   s_valid / s_ready  s_cell_in
// m_       out  m_valid / m_ready  m_cell_out, m_out_row, m_out_col, m_frame_end
// apb      in   psel / penable     paddr, pwdata -> prdata, pready
//
// One input transfer per cycle except at row ends and stalls; a row's last cell also goes
// through ST_END, emitting its own result past the first row. The last cell of a frame holds
// s_ready low while the event sequencer sweeps the single-read-port line store to flush the final row.
// Synchronous reset clears the position counters, window and output valid; line store
// contents are undefined until written. A stall on m_ready stalls the sequencer and s_ready.
module cellular_automaton_smoothing_top #(
    parameter int LINE_MAX = 32,
    parameter int ROWS_MAX = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cas_pkg::APB_AW-1:0]    paddr,
    input  logic [cas_pkg::APB_DW-1:0]    pwdata,
    output logic [cas_pkg::APB_DW-1:0]    prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cell_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_cell_out,
    output logic [cas_pkg::OUT_ROW_W-1:0] m_out_row,
    output logic [cas_pkg::OUT_COL_W-1:0] m_out_col,
    output logic                          m_frame_end
);
    import cas_pkg::*;

    localparam int COL_W     = $clog2(LINE_MAX);
    localparam int J_W       = $clog2(LINE_MAX + 1);
    localparam int H_CFG_MAX = (1 << CFG_H_W) - 1;
    localparam int ROWS_EFF  = (ROWS_MAX < H_CFG_MAX) ? ROWS_MAX : H_CFG_MAX;
    localparam int ROW_W     = $clog2(ROWS_EFF);
    localparam int CMP_W     = CFG_W_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_NORM  = 4'b0010,
        ST_END   = 4'b0100,
        ST_FLUSH = 4'b1000
    } seq_state_t;

    cfg_t             cfg;
    seq_state_t       state_reg, state_next;
    logic [COL_W-1:0] in_col_reg, in_col_next, col_reg;
    logic [ROW_W-1:0] in_row_reg, in_row_next, row_reg;
    logic             bit_reg, last_col_reg, last_row_reg;
    logic [J_W-1:0]   fj_reg, fj_next, fj_inc;

    logic [CFG_W_W-1:0] w_eff, w_m1;
    logic [CFG_H_W-1:0] h_eff, h_m1;
    logic               last_col_in, last_row_in;
    logic               fj_at_w, fj_in, fj_inc_in;
    logic               row_ge1, row_ge2;
    logic               ev_valid, ev_ready, go, final_ev, accept;
    ev_t                ev;

    logic             lm_wr_en, lm_rd_en;
    logic [COL_W-1:0] lm_rd_addr;
    logic [1:0]       lm_rd_data;

    cas_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_comb begin
        if (cfg.frame_width == '0) begin
            w_eff = CFG_W_W'(1);
        end else if (cfg.frame_width > CFG_W_W'(LINE_MAX)) begin
            w_eff = CFG_W_W'(LINE_MAX);
        end else begin
            w_eff = cfg.frame_width;
        end
        if (cfg.frame_height == '0) begin
            h_eff = CFG_H_W'(1);
        end else if (cfg.frame_height > CFG_H_W'(ROWS_EFF)) begin
            h_eff = CFG_H_W'(ROWS_EFF);
        end else begin
            h_eff = cfg.frame_height;
        end
    end

    assign w_m1        = w_eff - CFG_W_W'(1);
    assign h_m1        = h_eff - CFG_H_W'(1);
    assign last_col_in = CFG_W_W'(in_col_reg) >= w_m1;
    assign last_row_in = CFG_H_W'(in_row_reg) >= h_m1;

    assign fj_inc    = fj_reg + J_W'(1);
    assign fj_at_w   = CMP_W'(fj_reg) == CMP_W'(w_eff);
    assign fj_in     = CMP_W'(fj_reg) < CMP_W'(w_eff);
    assign fj_inc_in = CMP_W'(fj_inc) < CMP_W'(w_eff);
    assign row_ge1   = row_reg != '0;
    assign row_ge2   = row_reg > ROW_W'(1);

    assign ev_valid = state_reg != ST_IDLE;
    assign go       = ev_valid && ev_ready;
    assign final_ev = (state_reg == ST_NORM  && !last_col_reg)
                   || (state_reg == ST_END   && !last_row_reg)
                   || (state_reg == ST_FLUSH && fj_at_w);
    assign s_ready  = (state_reg == ST_IDLE) || (go && final_ev);
    assign accept   = s_valid && s_ready;

    always_comb begin
        ev = '0;
        case (state_reg)
            ST_NORM: begin
                ev.clear = col_reg == '0;
                ev.top   = row_ge2 && lm_rd_data[1];
                ev.mid   = row_ge1 && lm_rd_data[0];
                ev.bot   = bit_reg;
                ev.emit  = row_ge1 && (col_reg != '0);
                ev.row   = OUT_ROW_W'(row_reg - ROW_W'(1));
                ev.col   = OUT_COL_W'(col_reg - COL_W'(1));
            end
            ST_END: begin
                ev.emit = row_ge1;
                ev.row  = OUT_ROW_W'(row_reg - ROW_W'(1));
                ev.col  = OUT_COL_W'(col_reg);
            end
            ST_FLUSH: begin
                ev.clear     = fj_reg == '0;
                ev.top       = fj_in && row_ge1 && lm_rd_data[1];
                ev.mid       = fj_in && lm_rd_data[0];
                ev.emit      = fj_reg != '0;
                ev.row       = OUT_ROW_W'(row_reg);
                ev.col       = OUT_COL_W'(fj_reg - J_W'(1));
                ev.frame_end = fj_at_w;
            end
            default: ev = '0;
        endcase
    end

    // line store: write on the row's own event, read ahead for the next cell or flush column
    assign lm_wr_en = go && (state_reg == ST_NORM);
    assign lm_rd_en = accept || (go && state_reg == ST_END && last_row_reg)
                   || (go && state_reg == ST_FLUSH);

    always_comb begin
        if (accept) begin
            lm_rd_addr = in_col_reg;
        end else if (state_reg == ST_FLUSH && fj_inc_in) begin
            lm_rd_addr = COL_W'(fj_inc);
        end else begin
            lm_rd_addr = '0;
        end
    end

    cas_line_store #(
        .LINE_MAX (LINE_MAX)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (lm_wr_en),
        .wr_addr (col_reg),
        .wr_data ({lm_rd_data[0], bit_reg}),
        .rd_en   (lm_rd_en),
        .rd_addr (lm_rd_addr),
        .rd_data (lm_rd_data)
    );

    always_comb begin
        state_next = state_reg;
        fj_next    = fj_reg;
        if (go) begin
            case (state_reg)
                ST_NORM:  state_next = last_col_reg ? ST_END : ST_IDLE;
                ST_END: begin
                    state_next = last_row_reg ? ST_FLUSH : ST_IDLE;
                    fj_next    = '0;
                end
                ST_FLUSH: begin
                    state_next = fj_at_w ? ST_IDLE : ST_FLUSH;
                    fj_next    = fj_inc;
                end
                default:  state_next = ST_IDLE;
            endcase
        end
        if (accept) begin
            state_next = ST_NORM;
        end
    end

    always_comb begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        if (accept) begin
            if (last_col_in && last_row_in) begin
                in_col_next = '0;
                in_row_next = '0;
            end else if (last_col_in) begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fj_reg     <= '0;
            in_col_reg <= '0;
            in_row_reg <= '0;
        end else begin
            state_reg  <= state_next;
            fj_reg     <= fj_next;
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            col_reg      <= in_col_reg;
            row_reg      <= in_row_reg;
            bit_reg      <= s_cell_in;
            last_col_reg <= last_col_in;
            last_row_reg <= last_row_in;
        end
    end

    cas_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .ev_valid    (ev_valid),
        .ev          (ev),
        .ev_ready    (ev_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_cell_out  (m_cell_out),
        .m_out_row   (m_out_row),
        .m_out_col   (m_out_col),
        .m_frame_end (m_frame_end)
    );

endmodule

FILE: src/cas_checker.sv
module cas_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_cell_out,
    input logic [cas_pkg::OUT_ROW_W-1:0] m_out_row,
    input logic [cas_pkg::OUT_COL_W-1:0] m_out_col,
    input logic                          m_frame_end
);

    // out of reset: ready for input, nothing pending on the output
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> (s_ready && !m_valid))
        else $error("not idle after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable({m_cell_out, m_out_row, m_out_col, m_frame_end}))
        else $error("result changed while stalled");

    // a new frame cannot produce a result in the cycle after frame end transfer
    a_frame_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_frame_end |=> !m_valid)
        else $error("result straight after frame end");

endmodule

bind cellular_automaton_smoothing_top cas_checker u_cas_checker (.*);

FILE: tb/cellular_automaton_smoothing_top_tb.sv
`timescale 1ns / 100ps

module cellular_automaton_smoothing_top_tb;
    import cas_pkg::*;

    localparam int LINE_CELLS   = 32;
    localparam int MAX_ROWS     = 1024;
    localparam int RANDOM_ITEMS = 260;
    localparam int SETTLE       = 40;
    localparam int CYCLE_LIMIT  = 8_000_000;
    localparam int PRINT_CAP    = 50;

    typedef struct packed {
        logic                 cell_bit;
        logic [OUT_ROW_W-1:0] row;
        logic [OUT_COL_W-1:0] col;
        logic                 fe;
    } smoothed_cell_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [APB_AW-1:0]    paddr     = '0;
    logic [APB_DW-1:0]    pwdata    = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic                 s_cell_in = 1'b0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_cell_out;
    logic [OUT_ROW_W-1:0] m_out_row;
    logic [OUT_COL_W-1:0] m_out_col;
    logic                 m_frame_end;

    // predictor state
    logic [CFG_W_W-1:0]      cfg_width  = RST_FRAME_WIDTH;
    logic [CFG_H_W-1:0]      cfg_height = RST_FRAME_HEIGHT;
    logic [THR_W-1:0]        thr_low    = RST_LOW_THRESHOLD;
    logic [THR_W-1:0]        thr_high   = RST_HIGH_THRESHOLD;
    logic [2*LINE_CELLS-1:0] line_bits  = '0;
    logic [WIN_W-1:0]        win_bits   = '0;
    int unsigned             scan_row   = 0;
    int unsigned             scan_col   = 0;

    logic           raster_q[$];
    smoothed_cell_t smoothed_q[$];

    logic s_taken        = 1'b0;
    int   s_gap          = 0;
    int   s_calm         = 0;
    int   m_hold         = 0;
    int   m_calm         = 0;
    int   cells_sent     = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;

    cellular_automaton_smoothing_top #(
        .LINE_MAX(LINE_CELLS),
        .ROWS_MAX(MAX_ROWS)
    ) u_dut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned eff_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > LINE_CELLS) return LINE_CELLS;
        return cfg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (cfg_height == 0) return 1;
        if (cfg_height > MAX_ROWS) return MAX_ROWS;
        return cfg_height;
    endfunction

    function automatic void shift_column(logic top, logic mid, logic bot);
        win_bits = ((win_bits << 1) & WIN_KEEP_MASK) | WIN_W'({bot, 2'b00, mid, 2'b00, top});
    endfunction

    function automatic void queue_result(int unsigned row, int unsigned col, logic fe);
        smoothed_cell_t r;
        int             cnt;
        cnt = $countones(win_bits & WIN_NEIGH_MASK);
        if (cnt < thr_low) begin
            r.cell_bit = 1'b0;
        end else if (cnt >= thr_high) begin
            r.cell_bit = 1'b1;
        end else begin
            r.cell_bit = win_bits[WIN_CENTRE];
        end
        r.row = OUT_ROW_W'(row);
        r.col = OUT_COL_W'(col);
        r.fe  = fe;
        smoothed_q.push_back(r);
    endfunction

    function automatic void predict_smoothing(logic cell_bit);
        int unsigned w, h, c, r, k;
        logic        up1, up2;
        bit          last_c, last_r;
        w = eff_width();
        h = eff_height();
        c = (scan_col < LINE_CELLS) ? scan_col : LINE_CELLS - 1;
        r = scan_row;
        up1 = (r >= 1) ? line_bits[c] : 1'b0;
        up2 = (r >= 2) ? line_bits[LINE_CELLS + c] : 1'b0;
        last_c = (c >= w - 1);
        last_r = (r >= h - 1);
        if (c == 0) win_bits = '0;
        shift_column(up2, up1, cell_bit);
        line_bits[LINE_CELLS + c] = line_bits[c];
        line_bits[c] = cell_bit;
        if (r >= 1) begin
            if (c >= 1) queue_result(r - 1, c - 1, 1'b0);
            if (last_c) begin
                shift_column(1'b0, 1'b0, 1'b0);
                queue_result(r - 1, c, 1'b0);
            end
        end
        if (last_c && last_r) begin
            // flush the final row of the frame
            win_bits = '0;
            shift_column((r >= 1) ? line_bits[LINE_CELLS] : 1'b0, line_bits[0], 1'b0);
            for (k = 0; k < w; k++) begin
                if (k + 1 < w) begin
                    shift_column((r >= 1) ? line_bits[LINE_CELLS + k + 1] : 1'b0,
                                 line_bits[k + 1], 1'b0);
                end else begin
                    shift_column(1'b0, 1'b0, 1'b0);
                end
                queue_result(r, k, k == w - 1);
            end
            scan_row = 0;
            scan_col = 0;
        end else if (last_c) begin
            scan_col = 0;
            scan_row = r + 1;
        end else begin
            scan_col = c + 1;
        end
    endfunction

    // cells still needed to close the frame from the current scan position
    function automatic int cells_left();
        int unsigned w, h, r, c;
        int          n;
        w = eff_width();
        h = eff_height();
        r = scan_row;
        c = (scan_col < LINE_CELLS) ? scan_col : LINE_CELLS - 1;
        n = 1;
        while (!(c >= w - 1 && r >= h - 1)) begin
            if (c >= w - 1) begin
                c = 0;
                r++;
            end else begin
                c++;
            end
            n++;
        end
        return n;
    endfunction

    function automatic int idle_len(inout int calm);
        int r;
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        if ($urandom_range(0, 39) == 0) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string what);
        if (mismatch_count < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic send_cells(int n, int density);
        repeat (n) raster_q.push_back($urandom_range(0, 99) < density);
        cells_sent += n;
    endtask

    task automatic drain();
        while (raster_q.size() != 0 || s_valid || smoothed_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({idx, 2'b00});
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:    cfg_width  = value[CFG_W_W-1:0];
            REG_FRAME_HEIGHT:   cfg_height = value[CFG_H_W-1:0];
            REG_LOW_THRESHOLD:  thr_low    = value[THR_W-1:0];
            REG_HIGH_THRESHOLD: thr_high   = value[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(int w, int h, int lo, int hi);
        drain();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_LOW_THRESHOLD, lo);
        write_reg(REG_HIGH_THRESHOLD, hi);
    endtask

    // input side: bookkeeping at the rising edge, drive at the falling edge
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) predict_smoothing(s_cell_in);
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (s_gap > 0) begin
                s_gap   <= s_gap - 1;
                s_valid <= 1'b0;
            end else if (raster_q.size() > 0) begin
                s_valid   <= 1'b1;
                s_cell_in <= raster_q.pop_front();
                s_gap     <= idle_len(s_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_hold > 0) begin
            m_hold  <= m_hold - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            m_hold  <= idle_len(m_calm);
        end
    end

    always @(posedge aclk) begin : result_check
        smoothed_cell_t want;
        if (aresetn && m_valid && m_ready) begin
            if (smoothed_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer at (%0d,%0d)",
                                          m_out_row, m_out_col));
            end else begin
                want = smoothed_q.pop_front();
                if (m_out_row !== want.row)
                    report_mismatch($sformatf("out_row got %0d want %0d", m_out_row, want.row));
                if (m_out_col !== want.col)
                    report_mismatch($sformatf("out_col got %0d want %0d", m_out_col, want.col));
                if (m_cell_out !== want.cell_bit)
                    report_mismatch($sformatf("cell_out at (%0d,%0d) got %b want %b",
                                              want.row, want.col, m_cell_out, want.cell_bit));
                if (m_frame_end !== want.fe)
                    report_mismatch($sformatf("frame_end at (%0d,%0d) got %b want %b",
                                              want.row, want.col, m_frame_end, want.fe));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin : stimulus
        int       base, total, dens, d, wv, hv, lo, hi;
        reg_idx_t idx;
        logic [APB_DW-1:0] v;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // full-width frame first so both rows of the line store hold known data
        configure(32, 2, RST_LOW_THRESHOLD, RST_HIGH_THRESHOLD);
        send_cells(64, 50);
        configure(1, 1, 0, 0);
        send_cells(1, 100);
        send_cells(1, 0);
        // zero sizes act as one; thresholds past eight
        configure(0, 0, 9, 9);
        send_cells(1, 100);
        send_cells(1, 0);
        configure(63, 1, 15, 15);
        send_cells(32, 100);
        configure(3, 3, 2, 5);
        send_cells(9, 100);
        send_cells(9, 50);
        // height beyond the row limit, one cell per row, cut short mid-frame
        configure(1, 2047, 1, 2);
        send_cells(40, 50);
        drain();
        write_reg(REG_FRAME_HEIGHT, 8);
        send_cells(cells_left(), 50);

        // mid-frame changes
        configure(8, 4, 3, 5);
        send_cells(13, 50);
        drain();
        write_reg(REG_FRAME_WIDTH, 4);
        send_cells(cells_left(), 50);
        configure(6, 5, 2, 6);
        send_cells(15, 60);
        drain();
        write_reg(REG_FRAME_HEIGHT, 2);
        send_cells(cells_left(), 60);
        configure(4, 3, 3, 6);
        send_cells(6, 50);
        drain();
        write_reg(REG_FRAME_WIDTH, 32);
        write_reg(REG_LOW_THRESHOLD, 1);
        send_cells(cells_left(), 50);

        base = cells_sent;
        while (cells_sent - base < RANDOM_ITEMS) begin
            d = $urandom_range(0, 99);
            if (d < 60) wv = $urandom_range(1, 8);
            else if (d < 92) wv = $urandom_range(9, 32);
            else wv = $urandom_range(0, 1) ? 0 : $urandom_range(33, 63);
            d = $urandom_range(0, 99);
            if (d < 75) hv = $urandom_range(1, 4);
            else if (d < 93) hv = $urandom_range(5, 8);
            else hv = 0;
            lo = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
            hi = ($urandom_range(0, 6) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
            configure(wv, hv, lo, hi);
            repeat ($urandom_range(1, 3)) begin
                total = eff_width() * eff_height();
                d = $urandom_range(0, 99);
                dens = (d < 10) ? 0 : (d < 20) ? 100 : $urandom_range(5, 95);
                if (total > 1 && $urandom_range(0, 4) == 0) begin
                    send_cells($urandom_range(1, total - 1), dens);
                    drain();
                    idx = reg_idx_t'($urandom_range(0, 3));
                    case (idx)
                        REG_FRAME_WIDTH:  v = $urandom_range(0, 63);
                        REG_FRAME_HEIGHT: v = $urandom_range(0, 8);
                        default:          v = $urandom_range(0, 15);
                    endcase
                    write_reg(idx, v);
                    send_cells(cells_left(), dens);
                end else begin
                    send_cells(total, dens);
                end
            end
        end

        drain();
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
